/* src/protocol_path_interning_table_assert.svh */
// assertion macros used by the checker file
`ifndef PROTOCOL_PATH_INTERNING_TABLE_ASSERT_SVH
`define PROTOCOL_PATH_INTERNING_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PPIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PPIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ppit_pkg.sv */
package ppit_pkg;

  localparam int KEY_W     = 40;
  localparam int PATH_ID_W = 9;

  typedef struct packed {
    logic [4:0]  layer_kind;
    logic [2:0]  ident_kind;
    logic [31:0] ident_value;
    logic        last;
  } layer_item_t;

  typedef enum logic [1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_ADDED    = 2'd1,
    STATUS_TOO_LONG = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [PATH_ID_W-1:0] path_id;
    status_t              status;
  } result_item_t;

  // stored key layout: ident_value above ident_kind above layer_kind
  typedef struct packed {
    logic [31:0] ident_value;
    logic [2:0]  ident_kind;
    logic [4:0]  layer_kind;
  } layer_key_t;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'd0,
    ST_READ    = 2'd1,
    ST_CMP     = 2'd2,
    ST_EMIT    = 2'd3
  } state_t;

  typedef struct packed {
    logic shift;
    logic match;
  } cell_link_t;

endpackage

/* src/ppit_ram.sv */
module ppit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ppit_cell.sv */
module ppit_cell import ppit_pkg::*; #(
  parameter int IDX = 0,
  parameter int LW  = 4
) (
  input  logic       clk,
  input  cell_link_t link_in,
  input  layer_key_t key_in,
  input  logic [LW-1:0] len,
  input  layer_key_t row_key,
  output layer_key_t key,
  output cell_link_t link_out
);

  logic active;

  // shift line of buffered layers, newest in cell 0
  always_ff @(posedge clk) begin
    if (link_in.shift) begin
      key <= key_in;
    end
  end

  assign active = (LW'(IDX) < len);

  always_comb begin
    link_out.shift = link_in.shift;
    link_out.match = link_in.match && (!active || (key == row_key));
  end

endmodule

/* src/protocol_path_interning_table.sv */
// channel | direction | payload       | handshake
// layer   | in        | layer_item_t  | layer_valid / layer_stall
// result  | out       | result_item_t | result_valid / result_stall
//
// a layer without last is taken in ST_COLLECT; a last layer then steps
// through ST_READ and ST_CMP per stored path compared (one ram read and one
// compare each), so the search over the path table ram sets the cost of a lookup
// rst is synchronous and clears the fill count, pending length and flags;
// the path table holds no reset and is read only below the fill count
// layer_stall is high from the last layer until its result is loaded into
// the output register; a stalled result holds there while layers collect
module protocol_path_interning_table import ppit_pkg::*; #(
  parameter int MAX_LAYERS = 8,
  parameter int MAX_PATHS  = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         layer_valid,
  output logic         layer_stall,
  input  layer_item_t  layer,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  localparam int LW = $clog2(MAX_LAYERS + 1);
  localparam int CW = $clog2(MAX_PATHS + 1);
  localparam int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int RW = LW + KEY_W * MAX_LAYERS;

  state_t          state, state_next;
  logic [LW-1:0]   len, len_next;
  logic            too_long, too_long_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   slot, slot_next;
  result_item_t    res, res_next;
  result_item_t    result_next;
  logic            result_valid_next;

  logic            accept;
  logic            tl_now;
  logic            out_free;
  logic            found;
  logic            ram_we, ram_re;
  logic [RW-1:0]   row_rd, row_wr;
  layer_key_t      new_key;
  layer_key_t      cell_key [MAX_LAYERS];
  cell_link_t      link [MAX_LAYERS+1];

  assign accept   = layer_valid && !layer_stall;
  // a layer arriving with the buffer full marks the path as over-long
  assign tl_now   = too_long || (len == LW'(MAX_LAYERS));
  assign out_free = !result_valid || !result_stall;

  assign new_key = '{ident_value: layer.ident_value,
                     ident_kind:  layer.ident_kind,
                     layer_kind:  layer.layer_kind};

  // head of the cell chain: shift on a kept layer, match starts true
  assign link[0] = '{shift: accept && !tl_now, match: 1'b1};

  genvar j;
  generate
    for (j = 0; j < MAX_LAYERS; j++) begin : g_cell
      layer_key_t prev_key;
      if (j == 0) begin : g_head
        assign prev_key = new_key;
      end else begin : g_body
        assign prev_key = cell_key[j-1];
      end
      ppit_cell #(.IDX(j), .LW(LW)) u_cell (
        .clk      (clk),
        .link_in  (link[j]),
        .key_in   (prev_key),
        .len      (len),
        .row_key  (row_rd[LW + KEY_W*j +: KEY_W]),
        .key      (cell_key[j]),
        .link_out (link[j+1])
      );
      assign row_wr[LW + KEY_W*j +: KEY_W] = cell_key[j];
    end
  endgenerate

  // row layout: length in the low bits, cell keys above
  assign row_wr[LW-1:0] = len;

  // whole path matches: every active cell agrees and lengths are equal
  assign found = link[MAX_LAYERS].match && (row_rd[LW-1:0] == len);

  ppit_ram #(.WIDTH(RW), .DEPTH(MAX_PATHS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (row_wr),
    .re    (ram_re),
    .raddr (slot[AW-1:0]),
    .rdata (row_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (accept && layer.last) begin
          if (tl_now || (count == '0)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        if (found || (slot + CW'(1) == count)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    layer_stall = 1'b1;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    case (state)
      ST_COLLECT: layer_stall = 1'b0;
      ST_READ:    ram_re      = 1'b1;
      ST_CMP:     ram_re      = 1'b0;
      ST_EMIT:    ram_we      = out_free && (res.status == STATUS_ADDED);
      default:    layer_stall = 1'b1;
    endcase
  end

  // datapath next values
  always_comb begin
    len_next          = len;
    too_long_next     = too_long;
    count_next        = count;
    slot_next         = slot;
    res_next          = res;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    case (state)
      ST_COLLECT: begin
        if (accept) begin
          if (tl_now) begin
            too_long_next = 1'b1;
          end else begin
            len_next = len + LW'(1);
          end
          if (layer.last) begin
            slot_next = '0;
            if (tl_now) begin
              res_next = '{path_id: '0, status: STATUS_TOO_LONG};
            end else begin
              // empty table: nothing to search
              res_next = '{path_id: PATH_ID_W'(1), status: STATUS_ADDED};
            end
          end
        end
      end
      ST_CMP: begin
        if (found) begin
          res_next = '{path_id: PATH_ID_W'(slot + CW'(1)), status: STATUS_FOUND};
        end else if (slot + CW'(1) == count) begin
          if (count == CW'(MAX_PATHS)) begin
            res_next = '{path_id: '0, status: STATUS_FULL};
          end else begin
            res_next = '{path_id: PATH_ID_W'(count + CW'(1)), status: STATUS_ADDED};
          end
        end else begin
          slot_next = slot + CW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          result_next       = res;
          result_valid_next = 1'b1;
          len_next          = '0;
          too_long_next     = 1'b0;
          if (res.status == STATUS_ADDED) begin
            count_next = count + CW'(1);
          end
        end
      end
      default: begin
        len_next = len;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_COLLECT;
      len          <= '0;
      too_long     <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      len          <= len_next;
      too_long     <= too_long_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
    slot   <= slot_next;
    res    <= res_next;
    result <= result_next;
  end

endmodule

/* src/ppit_checker.sv */
`include "protocol_path_interning_table_assert.svh"

module ppit_checker import ppit_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         layer_valid,
  input logic         layer_stall,
  input layer_item_t  layer,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result
);

  `PPIT_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
  `PPIT_ASSERT_NXT(a_result_stable, result_valid && result_stall, $stable(result), "stalled result changed")
  `PPIT_ASSERT_IMP(a_fail_id_zero, result_valid && (result.status == STATUS_TOO_LONG || result.status == STATUS_FULL), result.path_id == '0, "failed lookup carries nonzero id")
  `PPIT_ASSERT_NXT(a_mid_layer_silent, layer_valid && !layer_stall && !layer.last, !$rose(result_valid), "result after a middle layer")

endmodule

bind protocol_path_interning_table ppit_checker u_ppit_checker (.*);

/* test/protocol_path_interning_table_tb.sv */
`timescale 1ns / 100ps

module protocol_path_interning_table_tb;
  import ppit_pkg::*;

  localparam int MAX_LAYERS = 8;
  localparam int MAX_PATHS  = 256;

  logic         clk;
  logic         rst;
  logic         layer_valid;
  logic         layer_stall;
  layer_item_t  layer;
  logic         result_valid;
  logic         result_stall;
  result_item_t result;

  protocol_path_interning_table #(
    .MAX_LAYERS(MAX_LAYERS),
    .MAX_PATHS (MAX_PATHS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .layer_valid (layer_valid),
    .layer_stall (layer_stall),
    .layer       (layer),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // shadow copy of the interning table
  layer_key_t  table_keys[MAX_PATHS][MAX_LAYERS];
  int unsigned table_lens[MAX_PATHS];
  int unsigned table_fill;
  layer_key_t  path_buf[MAX_LAYERS];
  int unsigned path_len;
  bit          path_overflow;

  result_item_t expected_ids[$];
  int unsigned  error_count;
  int unsigned  layers_sent;
  bit           idle_enable;

  // layers already interned, reused to force lookups that hit
  layer_item_t  known_paths[$][$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  // intern model: buffer one layer, resolve the path on last
  task automatic intern_layer(input layer_item_t li);
    layer_key_t   key;
    result_item_t r;
    bit           hit;
    key.layer_kind  = li.layer_kind;
    key.ident_kind  = li.ident_kind;
    key.ident_value = li.ident_value;
    hit = 1'b0;
    if (path_overflow || path_len >= MAX_LAYERS) begin
      path_overflow = 1'b1;
    end else begin
      path_buf[path_len] = key;
      path_len++;
    end
    if (!li.last) return;
    r.path_id = '0;
    if (path_overflow) begin
      r.status = STATUS_TOO_LONG;
    end else begin
      for (int s = 0; s < table_fill && !hit; s++) begin
        if (table_lens[s] == path_len) begin
          hit = 1'b1;
          for (int i = 0; i < path_len; i++)
            if (table_keys[s][i] != path_buf[i]) hit = 1'b0;
          if (hit) r.path_id = PATH_ID_W'(s + 1);
        end
      end
      if (hit) begin
        r.status = STATUS_FOUND;
      end else if (table_fill >= MAX_PATHS) begin
        r.status = STATUS_FULL;
      end else begin
        for (int i = 0; i < path_len; i++) table_keys[table_fill][i] = path_buf[i];
        table_lens[table_fill] = path_len;
        table_fill++;
        r.path_id = PATH_ID_W'(table_fill);
        r.status  = STATUS_ADDED;
      end
    end
    path_len      = 0;
    path_overflow = 1'b0;
    expected_ids.insert(expected_ids.size(), r);
  endtask

  // one transaction on the layer channel, random gap first
  task automatic send_layer(input layer_item_t li);
    while (idle_enable && $urandom_range(99) < 29) begin
      layer_valid <= 1'b0;
      @(negedge clk);
    end
    layer       <= li;
    layer_valid <= 1'b1;
    @(posedge clk);
    while (layer_stall) @(posedge clk);
    intern_layer(li);
    layers_sent++;
    @(negedge clk);
  endtask

  function automatic layer_item_t rand_layer(input bit is_last);
    layer_item_t li;
    li.layer_kind  = 5'($urandom);
    li.ident_kind  = 3'($urandom);
    // mostly small values so paths collide and hit the table
    li.ident_value = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
    if ($urandom_range(1)) li.layer_kind = 5'($urandom_range(2));
    if ($urandom_range(1)) li.ident_kind = 3'($urandom_range(1));
    li.last = is_last;
    return li;
  endfunction

  task automatic send_path(input int unsigned n);
    layer_item_t p[$];
    layer_item_t li;
    for (int i = 0; i < n; i++) begin
      li = rand_layer(i == n - 1);
      p.insert(p.size(), li);
      send_layer(li);
    end
    if (n <= MAX_LAYERS && known_paths.size() < 64)
      known_paths.insert(known_paths.size(), p);
  endtask

  task automatic resend_known();
    layer_item_t p[$];
    int k;
    k = $urandom_range(known_paths.size() - 1);
    p = known_paths[k];
    foreach (p[i]) send_layer(p[i]);
  endtask

  task automatic drain();
    layer_valid <= 1'b0;
    while (expected_ids.size() != 0) @(negedge clk);
  endtask

  // result checker: compare each transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_ids.size() == 0) begin
        $display("%0t unexpected result: actual id %0d status %0d",
                 $time, result.path_id, result.status);
        error_count++;
      end else begin
        result_item_t e;
        e = expected_ids.pop_front();
        if (result.path_id !== e.path_id) begin
          $display("%0t path_id mismatch: expected %0d actual %0d",
                   $time, e.path_id, result.path_id);
          error_count++;
        end
        if (result.status !== e.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, e.status, result.status);
          error_count++;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk)
    result_stall <= idle_enable && ($urandom_range(99) < 29);

  // field extremes, every ident kind, overflow and found paths
  task automatic test_directed();
    layer_item_t li;
    li = '{layer_kind: 5'd0, ident_kind: 3'd0, ident_value: 32'd0, last: 1'b1};
    send_layer(li);
    send_layer(li);
    li = '{layer_kind: 5'd31, ident_kind: 3'd7, ident_value: 32'hFFFF_FFFF, last: 1'b1};
    send_layer(li);
    for (int k = 0; k < 7; k++) begin
      li = '{layer_kind: 5'(k + 1), ident_kind: 3'(k), ident_value: 32'(k << 28),
             last: 1'b0};
      send_layer(li);
    end
    li.last = 1'b1;
    send_layer(li);
    // too long: nine layers, then ten
    for (int n = 9; n <= 10; n++)
      for (int i = 0; i < n; i++) begin
        li = '{layer_kind: 5'd3, ident_kind: 3'd1, ident_value: 32'(i), last: i == n - 1};
        send_layer(li);
      end
    // exactly max length, twice
    for (int r = 0; r < 2; r++)
      for (int i = 0; i < MAX_LAYERS; i++) begin
        li = '{layer_kind: 5'd9, ident_kind: 3'd2, ident_value: 32'hA5A5_0000 + i,
               last: i == MAX_LAYERS - 1};
        send_layer(li);
      end
  endtask

  // random paths, part of them with no idling at all
  task automatic test_random();
    int unsigned sent;
    int unsigned start;
    start = layers_sent;
    sent  = 0;
    while (sent < 1700) begin
      idle_enable = !(sent > 600 && sent < 900);
      case ($urandom_range(9))
        0: begin
          send_path(MAX_LAYERS + 1 + $urandom_range(3));
        end
        1, 2, 3: if (known_paths.size() != 0) begin
          resend_known();
        end
        default: begin
          send_path($urandom_range(1, MAX_LAYERS));
        end
      endcase
      sent = layers_sent - start;
      if (sent % 400 < 4) drain();
    end
    idle_enable = 1'b1;
  endtask

  // push past table capacity, then confirm stored paths still resolve
  task automatic test_table_full();
    layer_item_t li;
    while (table_fill < MAX_PATHS) begin
      li = '{layer_kind: 5'd30, ident_kind: 3'd5, ident_value: 32'(table_fill) ^ 32'h5000_0000,
             last: 1'b1};
      send_layer(li);
    end
    for (int i = 0; i < 20; i++) begin
      li = '{layer_kind: 5'd29, ident_kind: 3'd6, ident_value: $urandom, last: 1'b1};
      send_layer(li);
      if (known_paths.size() != 0) resend_known();
    end
    li = '{layer_kind: 5'd1, ident_kind: 3'd3, ident_value: 0, last: 1'b0};
    for (int i = 0; i < MAX_LAYERS + 2; i++) send_layer(li);
    li.last = 1'b1;
    send_layer(li);
  endtask

  initial begin
    rst          = 1'b1;
    layer_valid  = 1'b0;
    layer        = '0;
    result_stall = 1'b0;
    idle_enable  = 1'b1;
    error_count  = 0;
    layers_sent  = 0;
    table_fill   = 0;
    path_len     = 0;
    path_overflow = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    drain();
    test_random();
    test_table_full();

    fork
      drain();
      begin
        repeat (100000) @(negedge clk);
      end
    join_any
    disable fork;
    repeat (50) @(negedge clk);
    if (error_count == 0 && expected_ids.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
